@@ design/asterix_record_splitter_macros.svh @@
// ----------------------------------------------------------------------------
// asterix_record_splitter_macros
// Assertion macros used by the top-level design file of the splitter.
// ----------------------------------------------------------------------------
`ifndef ASTERIX_RECORD_SPLITTER_MACROS_SVH
`define ASTERIX_RECORD_SPLITTER_MACROS_SVH
// Checks that an antecedent implies a consequent in the same cycle.
`define ARS_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that an antecedent implies a consequent in the next cycle.
`define ARS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ design/ars_pkg.sv @@
// ----------------------------------------------------------------------------
// ars_pkg
// Types, constants and item tables of the record splitter.
// ----------------------------------------------------------------------------
package ars_pkg;

  localparam logic [7:0] CatA = 8'd34;
  localparam logic [7:0] CatB = 8'd48;
  localparam logic [4:0] NoItem = 5'd31;

  typedef enum logic [2:0] {
    PH_CAT   = 3'd0,
    PH_LENHI = 3'd1,
    PH_LENLO = 3'd2,
    PH_FSPEC = 3'd3,
    PH_ITEM  = 3'd4,
    PH_BODY  = 3'd5,
    PH_BAD   = 3'd6,
    PH_SPARE = 3'd7
  } phase_e;

  typedef enum logic [2:0] {
    K_FIXED    = 3'd0,
    K_EXTENDED = 3'd1,
    K_REPEAT   = 3'd2,
    K_EXPLICIT = 3'd3,
    K_COMPOUND = 3'd4
  } kind_e;

  typedef enum logic [1:0] {
    ROLE_HEADER = 2'd0,
    ROLE_RECORD = 2'd1,
    ROLE_IGNORED = 2'd2
  } role_e;

  typedef enum logic [2:0] {
    SS_HEAD   = 3'd0,
    SS_COUNT  = 3'd1,
    SS_EXT    = 3'd2,
    SS_REPB   = 3'd3
  } sub_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        payload_start;
  } in_t;

  typedef struct packed {
    logic [7:0]  byte_out;
    logic [1:0]  byte_role;
    logic        record_first;
    logic        record_last;
    logic [7:0]  block_cat;
    logic [15:0] record_bytes;
    logic        truncated;
  } out_t;

  typedef struct packed {
    kind_e      kind;
    logic [3:0] size;
  } item_info_t;

  function automatic item_info_t item_info(input logic is_a, input logic [4:0] it);
    item_info_t r;
    r.kind = K_FIXED;
    r.size = 4'd0;
    if (is_a) begin
      unique case (it)
        5'd0: r.size = 4'd2;
        5'd1: r.size = 4'd1;
        5'd2: r.size = 4'd3;
        5'd3: r.size = 4'd1;
        5'd4: r.size = 4'd2;
        5'd5, 5'd6: r.kind = K_COMPOUND;
        5'd7: begin r.kind = K_REPEAT; r.size = 4'd2; end
        5'd8: r.size = 4'd8;
        5'd9: r.size = 4'd1;
        5'd10: r.size = 4'd8;
        5'd11: r.size = 4'd2;
        default: r.kind = K_EXPLICIT;
      endcase
    end else begin
      unique case (it)
        5'd0: r.size = 4'd2;
        5'd1: r.size = 4'd3;
        5'd2: r.kind = K_EXTENDED;
        5'd3: r.size = 4'd4;
        5'd4: r.size = 4'd2;
        5'd5: r.size = 4'd2;
        5'd6: r.kind = K_COMPOUND;
        5'd7: r.size = 4'd3;
        5'd8: r.size = 4'd6;
        5'd9: begin r.kind = K_REPEAT; r.size = 4'd8; end
        5'd10: r.size = 4'd2;
        5'd11: r.size = 4'd4;
        5'd12: r.size = 4'd4;
        5'd13: r.kind = K_EXTENDED;
        5'd14: r.size = 4'd4;
        5'd15: r.kind = K_EXTENDED;
        5'd16: r.size = 4'd2;
        5'd17: r.size = 4'd4;
        5'd18: r.size = 4'd2;
        5'd19: r.kind = K_COMPOUND;
        5'd20: r.size = 4'd2;
        5'd21: r.size = 4'd7;
        5'd22: r.size = 4'd1;
        5'd23: r.size = 4'd2;
        5'd24: r.size = 4'd1;
        5'd25: r.size = 4'd2;
        default: r.kind = K_EXPLICIT;
      endcase
    end
    return r;
  endfunction

  // Lowest present item at or above from, below the category's limit.
  function automatic logic [4:0] next_item(input logic [27:0] present,
                                           input logic is_a, input logic [5:0] from);
    logic [4:0] k;
    logic       found;
    k = NoItem;
    found = 1'b0;
    for (int i = 0; i < 28; i++) begin
      if (!found && present[i] && (6'(i) >= from) && (!is_a || i < 14)) begin
        k = 5'(i);
        found = 1'b1;
      end
    end
    return k;
  endfunction

endpackage

@@ design/ars_stream_if.sv @@
// ----------------------------------------------------------------------------
// ars_stream_if
// Valid/ready channels carrying an input byte or a tagged result byte.
// ----------------------------------------------------------------------------
interface ars_in_if;
  import ars_pkg::*;
  logic valid;
  logic ready;
  in_t  payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface ars_out_if;
  import ars_pkg::*;
  logic valid;
  logic ready;
  out_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

@@ design/ars_parser.sv @@
// ----------------------------------------------------------------------------
// ars_parser
// Parse state and per-byte tagging; one byte a cycle when advanced.
// ----------------------------------------------------------------------------
module ars_parser import ars_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic step_i,
  input  in_t  in_i,
  output out_t res_o
);

  phase_e      phase_q, phase_d;
  logic [7:0]  cat_q, cat_d;
  logic [15:0] blk_q, blk_d;
  logic [27:0] pres_q, pres_d;
  logic [4:0]  item_q, item_d;
  logic [10:0] ibl_q, ibl_d;
  logic [2:0]  sub_q, sub_d;
  logic        pend_q, pend_d;
  logic [15:0] rc_q, rc_d;

  always_comb begin
    logic [7:0]  b;
    logic [15:0] len;
    logic        known, is_a, done, blk_end, item_done, last;
    logic [1:0]  idx;
    item_info_t  inf;
    logic [4:0]  it, nk;
    phase_e      ph;
    b = in_i.data_byte;
    phase_d = phase_q; cat_d = cat_q; blk_d = blk_q; pres_d = pres_q;
    item_d = item_q; ibl_d = ibl_q; sub_d = sub_q; pend_d = pend_q; rc_d = rc_q;
    res_o = '0;
    res_o.byte_out = b;
    done = 1'b0; item_done = 1'b0; last = 1'b0; blk_end = 1'b0;
    len = '0; idx = '0; it = '0; nk = '0; inf = '0;
    if (in_i.payload_start) begin
      phase_d = PH_CAT; blk_d = '0; pres_d = '0; item_d = '0; ibl_d = '0;
      sub_d = '0; pend_d = 1'b0; rc_d = '0;
    end
    ph = phase_d;
    known = (cat_d == CatA) || (cat_d == CatB);
    is_a = (cat_d == CatA);
    unique case (ph)
      PH_CAT: begin
        cat_d = b; phase_d = PH_LENHI;
      end
      PH_LENHI: begin
        blk_d = {b, 8'h00}; phase_d = PH_LENLO;
      end
      PH_LENLO: begin
        len = {blk_d[15:8], b};
        pres_d = '0; item_d = '0; ibl_d = '0; sub_d = '0; pend_d = 1'b0; rc_d = '0;
        if (len < 16'd3) begin
          blk_d = '0; phase_d = PH_BAD;
        end else if (len == 16'd3) begin
          blk_d = '0; phase_d = PH_CAT;
        end else begin
          blk_d = len - 16'd3; phase_d = PH_FSPEC;
        end
      end
      PH_FSPEC, PH_ITEM, PH_BODY: begin
        res_o.byte_role = ROLE_RECORD;
        res_o.record_first = (rc_d == '0);
        rc_d = rc_d + 16'd1;
        if (blk_d != '0) blk_d = blk_d - 16'd1;
        blk_end = (blk_d == '0);
        if (ph == PH_FSPEC) begin
          idx = sub_d[1:0];
          for (int j = 0; j < 7; j++) begin
            if (b[7-j]) pres_d[7*idx + j] = 1'b1;
          end
          if (b[0] && idx < 2'd3) begin
            sub_d = {1'b0, idx + 2'd1};
          end else begin
            sub_d = '0;
            if (known) begin
              nk = next_item(pres_d, is_a, 6'd0);
              if (nk == NoItem) done = 1'b1;
              else begin item_d = nk; phase_d = PH_ITEM; end
            end else begin
              phase_d = PH_BODY;
            end
          end
        end else if (ph == PH_ITEM) begin
          it = item_d;
          if (is_a && it > 5'd13) it = 5'd13;
          if (!is_a && it > 5'd27) it = 5'd27;
          inf = item_info(is_a, it);
          unique case (sub_d)
            SS_HEAD: begin
              pend_d = 1'b0; ibl_d = '0;
              unique case (inf.kind)
                K_FIXED: ibl_d = 11'(inf.size) - 11'd1;
                K_EXTENDED: if (b[0]) sub_d = SS_EXT; else item_done = 1'b1;
                K_REPEAT: ibl_d = 11'(b) * 11'(inf.size);
                K_EXPLICIT: ibl_d = (b > 8'd1) ? 11'(b - 8'd1) : 11'd0;
                default: begin
                  if (is_a && it == 5'd5)
                    ibl_d = 11'(b[7]) + 11'(b[4]) + 11'(b[3]) + {9'd0, b[2], 1'b0};
                  else if (is_a)
                    ibl_d = 11'($countones(b & 8'h9C));
                  else if (it == 5'd6)
                    ibl_d = 11'($countones(b & 8'hFE));
                  else begin
                    ibl_d = b[7] ? 11'd2 : 11'd0;
                    pend_d = b[6];
                  end
                end
              endcase
              if (sub_d == SS_HEAD && !item_done) begin
                if (ibl_d != '0) sub_d = SS_COUNT;
                else if (pend_d) sub_d = SS_REPB;
                else item_done = 1'b1;
              end
            end
            SS_COUNT: begin
              if (ibl_d != '0) ibl_d = ibl_d - 11'd1;
              if (ibl_d == '0) begin
                if (pend_d) sub_d = SS_REPB; else item_done = 1'b1;
              end
            end
            SS_EXT: if (!b[0]) item_done = 1'b1;
            default: begin
              pend_d = 1'b0;
              ibl_d = 11'(b) * 11'd6;
              if (ibl_d != '0) sub_d = SS_COUNT; else item_done = 1'b1;
            end
          endcase
          if (item_done) begin
            sub_d = '0; ibl_d = '0; pend_d = 1'b0;
            nk = next_item(pres_d, is_a, 6'(it) + 6'd1);
            if (nk == NoItem) done = 1'b1; else item_d = nk;
          end
        end
        if (known) begin
          last = done || blk_end;
          res_o.truncated = blk_end && !done;
        end else begin
          last = blk_end;
          res_o.truncated = blk_end && (phase_d == PH_FSPEC);
        end
        res_o.record_last = last;
        res_o.record_bytes = rc_d;
        if (last) begin
          pres_d = '0; item_d = '0; ibl_d = '0; sub_d = '0; pend_d = 1'b0; rc_d = '0;
          phase_d = blk_end ? PH_CAT : PH_FSPEC;
        end
      end
      default: res_o.byte_role = ROLE_IGNORED;
    endcase
    res_o.block_cat = cat_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_CAT; cat_q <= '0; blk_q <= '0; pres_q <= '0; item_q <= '0;
      ibl_q <= '0; sub_q <= '0; pend_q <= 1'b0; rc_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d; cat_q <= cat_d; blk_q <= blk_d; pres_q <= pres_d;
      item_q <= item_d; ibl_q <= ibl_d; sub_q <= sub_d; pend_q <= pend_d; rc_q <= rc_d;
    end
  end

endmodule

@@ design/asterix_record_splitter.sv @@
// ----------------------------------------------------------------------------
// asterix_record_splitter
// Splits surveillance-data blocks into records and tags every byte.
// ----------------------------------------------------------------------------
// One result beat leaves for every input beat, valid in the cycle after the
// input beat is taken. The tags of a byte are worked out by short logic from
// the parse state registers and the incoming byte, and are loaded into the
// result register at the accepting edge, so a new beat is taken in every cycle
// as long as the result register is empty or is drained in the same cycle.
module asterix_record_splitter import ars_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  ars_in_if.sink    in_i,
  ars_out_if.source out_o
);
`include "asterix_record_splitter_macros.svh"

  out_t res;
  out_t out_q;
  logic out_valid_q;
  logic step;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign step = in_i.valid && in_i.ready;

  ars_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .in_i   (in_i.payload),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      out_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) out_q <= res;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.payload = out_q;

  `ARS_ASSERT_NEXT(a_one_result, clk_i, rst_ni, step, out_valid_q)
  `ARS_ASSERT_IMPLY(a_trunc_last, clk_i, rst_ni, out_valid_q && out_q.truncated,
    out_q.record_last)
  `ARS_ASSERT_IMPLY(a_header_quiet, clk_i, rst_ni,
    out_valid_q && out_q.byte_role != ROLE_RECORD, out_q.record_bytes == '0)

endmodule

@@ sim/ars_tag_checker.sv @@
// ----------------------------------------------------------------------------
// ars_tag_checker
// Watches both channels of the record splitter, works out the tags that every
// accepted byte must get and compares them with the result beats in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ars_tag_checker import ars_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_ready_i,
  input  in_t  in_payload_i,
  input  logic out_valid_i,
  input  logic out_ready_i,
  input  out_t out_payload_i,
  output int   fail_count_o,
  output int   tags_waiting_o
);

  localparam kind_e Kind34 [14] = '{K_FIXED, K_FIXED, K_FIXED, K_FIXED, K_FIXED,
    K_COMPOUND, K_COMPOUND, K_REPEAT, K_FIXED, K_FIXED, K_FIXED, K_FIXED,
    K_EXPLICIT, K_EXPLICIT};
  localparam int Size34 [14] = '{2, 1, 3, 1, 2, 0, 0, 2, 8, 1, 8, 2, 0, 0};
  localparam kind_e Kind48 [28] = '{K_FIXED, K_FIXED, K_EXTENDED, K_FIXED, K_FIXED,
    K_FIXED, K_COMPOUND, K_FIXED, K_FIXED, K_REPEAT, K_FIXED, K_FIXED, K_FIXED,
    K_EXTENDED, K_FIXED, K_EXTENDED, K_FIXED, K_FIXED, K_FIXED, K_COMPOUND,
    K_FIXED, K_FIXED, K_FIXED, K_FIXED, K_FIXED, K_FIXED, K_EXPLICIT, K_EXPLICIT};
  localparam int Size48 [28] = '{2, 3, 0, 4, 2, 2, 0, 3, 6, 8, 2, 4, 4, 0,
                                 4, 0, 2, 4, 2, 0, 2, 7, 1, 2, 1, 2, 0, 0};

  // Parser state as the splitter should hold it.
  phase_e      ph;
  logic [7:0]  cur_cat;
  logic [15:0] blk_left;
  logic [27:0] present;
  logic [4:0]  item_no;
  int          item_left;
  logic [2:0]  sub;
  logic [7:0]  pend;
  logic [15:0] rec_count;

  out_t tags_q[$];
  int   fails;

  assign fail_count_o   = fails;
  assign tags_waiting_o = tags_q.size();

  function automatic void clear_record();
    present   = '0;
    item_no   = '0;
    item_left = 0;
    sub       = SS_HEAD;
    pend      = '0;
    rec_count = '0;
  endfunction

  function automatic logic [4:0] first_present(input int from);
    int lim;
    lim = (cur_cat == CatA) ? 14 : 28;
    for (int k = from; k < lim; k++) begin
      if (present[k]) return 5'(k);
    end
    return NoItem;
  endfunction

  function automatic int ones(input logic [7:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 8; i++) n += v[i];
    return n;
  endfunction

  // Walks one item byte; returns 1 when the record is complete.
  function automatic bit walk_item(input logic [7:0] b);
    bit    is_a;
    int    it;
    kind_e kd;
    int    sz;
    bit    item_done;
    is_a = (cur_cat == CatA);
    it = item_no;
    item_done = 0;
    if (is_a) begin
      if (it > 13) it = 13;
      kd = Kind34[it];
      sz = Size34[it];
    end else begin
      if (it > 27) it = 27;
      kd = Kind48[it];
      sz = Size48[it];
    end
    if (sub == SS_HEAD) begin
      pend = '0;
      item_left = 0;
      case (kd)
        K_FIXED:    item_left = sz - 1;
        K_EXTENDED: if (b[0]) sub = SS_EXT; else item_done = 1;
        K_REPEAT:   item_left = b * sz;
        K_EXPLICIT: item_left = (b > 1) ? b - 1 : 0;
        default: begin
          if (is_a && it == 5) item_left = b[7] + b[4] + b[3] + 2 * b[2];
          else if (is_a) item_left = ones(b & 8'h9C);
          else if (it == 6) item_left = ones(b & 8'hFE);
          else begin
            item_left = b[7] ? 2 : 0;
            pend = b & 8'h40;
          end
        end
      endcase
      if (sub == SS_HEAD && !item_done) begin
        if (item_left > 0) sub = SS_COUNT;
        else if (pend != 0) sub = SS_REPB;
        else item_done = 1;
      end
    end else if (sub == SS_COUNT) begin
      if (item_left > 0) item_left--;
      if (item_left == 0) begin
        if (pend != 0) sub = SS_REPB; else item_done = 1;
      end
    end else if (sub == SS_EXT) begin
      if (!b[0]) item_done = 1;
    end else begin
      // Repetition byte of the Doppler subfield: six bytes per repetition.
      pend = '0;
      item_left = b * 6;
      if (item_left > 0) sub = SS_COUNT; else item_done = 1;
    end
    if (!item_done) return 0;
    sub = SS_HEAD;
    item_left = 0;
    pend = '0;
    item_no = first_present(it + 1);
    if (item_no == NoItem) return 1;
    return 0;
  endfunction

  function automatic out_t tag_byte(input in_t x);
    out_t        t;
    logic [7:0]  b;
    logic [15:0] len;
    bit          known, done, blk_end;
    int          idx;
    logic [4:0]  k;
    b = x.data_byte;
    t = '0;
    t.byte_out = b;
    t.byte_role = ROLE_HEADER;
    if (x.payload_start) begin
      ph = PH_CAT;
      blk_left = '0;
      clear_record();
    end
    case (ph)
      PH_CAT: begin
        cur_cat = b;
        ph = PH_LENHI;
      end
      PH_LENHI: begin
        blk_left = {b, 8'h00};
        ph = PH_LENLO;
      end
      PH_LENLO: begin
        len = {blk_left[15:8], b};
        clear_record();
        if (len < 3) begin
          blk_left = '0;
          ph = PH_BAD;
        end else if (len == 3) begin
          blk_left = '0;
          ph = PH_CAT;
        end else begin
          blk_left = len - 16'd3;
          ph = PH_FSPEC;
        end
      end
      PH_FSPEC, PH_ITEM, PH_BODY: begin
        known = (cur_cat == CatA || cur_cat == CatB);
        done = 0;
        t.byte_role = ROLE_RECORD;
        t.record_first = (rec_count == 0);
        rec_count = rec_count + 16'd1;
        if (blk_left > 0) blk_left--;
        blk_end = (blk_left == 0);
        if (ph == PH_FSPEC) begin
          idx = sub[1:0];
          for (int j = 0; j < 7; j++) begin
            if (b[7-j]) present[7*idx+j] = 1'b1;
          end
          if (b[0] && idx < 3) begin
            sub = 3'(idx + 1);
          end else begin
            sub = SS_HEAD;
            if (known) begin
              k = first_present(0);
              if (k == NoItem) done = 1;
              else begin
                item_no = k;
                ph = PH_ITEM;
              end
            end else begin
              ph = PH_BODY;
            end
          end
        end else if (ph == PH_ITEM) begin
          done = walk_item(b);
        end
        if (known) begin
          t.record_last = done || blk_end;
          t.truncated = blk_end && !done;
        end else begin
          t.record_last = blk_end;
          t.truncated = blk_end && (ph == PH_FSPEC);
        end
        t.record_bytes = rec_count;
        if (t.record_last) begin
          clear_record();
          ph = blk_end ? PH_CAT : PH_FSPEC;
        end
      end
      default: t.byte_role = ROLE_IGNORED;
    endcase
    t.block_cat = cur_cat;
    return t;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    if (!rst_ni) begin
      ph = PH_CAT;
      cur_cat = '0;
      blk_left = '0;
      clear_record();
      tags_q.delete();
      fails = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (tags_q.size() == 0) begin
          fails++;
          if (fails <= 10) $display("unexpected result beat: %p", out_payload_i);
        end else begin
          want = tags_q.pop_front();
          if (want !== out_payload_i) begin
            fails++;
            if (fails <= 10) $display("tag mismatch: expected %p, got %p", want, out_payload_i);
          end
        end
      end
      if (in_valid_i && in_ready_i) tags_q.push_back(tag_byte(in_payload_i));
    end
  end

endmodule

@@ sim/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Drives payload bytes into the record splitter with random gaps and stalls;
// the tag checker beside the block predicts and compares every result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;
  import ars_pkg::*;

  localparam int CycleLimit = 200000;

  logic clk_i;
  logic rst_ni;

  ars_in_if  in_ch ();
  ars_out_if out_ch ();

  int fail_count;
  int tags_waiting;
  int tx_idle;
  int rx_idle;
  bit hold_req;
  int hold_left;
  int cycles;

  in_t        beat_q[$];
  logic [7:0] rec_q[$];

  asterix_record_splitter DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  ars_tag_checker u_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_ch.valid),
    .in_ready_i     (in_ch.ready),
    .in_payload_i   (in_ch.payload),
    .out_valid_i    (out_ch.valid),
    .out_ready_i    (out_ch.ready),
    .out_payload_i  (out_ch.payload),
    .fail_count_o   (fail_count),
    .tags_waiting_o (tags_waiting)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("testbench failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, plus one long hold-off when requested.
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready = 1'b0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= rx_idle);
      end
    end
  end

  function automatic void push_byte(input logic [7:0] b, input bit start);
    in_t x;
    x.data_byte = b;
    x.payload_start = start;
    beat_q.push_back(x);
  endfunction

  // Builds one well-formed record of the given category into rec_q.
  function automatic void build_record(input logic [7:0] cat);
    int         nf, lim, n, r;
    logic [7:0] fs;
    logic [27:0] pres;
    item_info_t info;
    bit         is_a, known;
    logic [7:0] b;
    is_a = (cat == CatA);
    known = is_a || (cat == CatB);
    nf = $urandom_range(1, 4);
    pres = '0;
    for (int i = 0; i < nf; i++) begin
      fs = 8'($urandom) & 8'($urandom) & 8'hFE;
      if (i < nf - 1 || (i == 3 && $urandom_range(0, 1))) fs[0] = 1'b1;
      rec_q.push_back(fs);
      for (int j = 0; j < 7; j++) if (fs[7-j]) pres[7*i+j] = 1'b1;
    end
    if (!known) begin
      n = $urandom_range(0, 6);
      repeat (n) rec_q.push_back(8'($urandom));
      return;
    end
    lim = is_a ? 14 : 28;
    for (int k = 0; k < lim; k++) begin
      if (!pres[k]) continue;
      info = item_info(is_a, 5'(k));
      case (info.kind)
        K_FIXED: repeat (info.size) rec_q.push_back(8'($urandom));
        K_EXTENDED: begin
          n = $urandom_range(0, 2);
          repeat (n) rec_q.push_back(8'($urandom) | 8'h01);
          rec_q.push_back(8'($urandom) & 8'hFE);
        end
        K_REPEAT: begin
          r = $urandom_range(0, 3);
          rec_q.push_back(8'(r));
          repeat (r * info.size) rec_q.push_back(8'($urandom));
        end
        K_EXPLICIT: begin
          r = $urandom_range(0, 8);
          rec_q.push_back(8'(r));
          if (r > 1) repeat (r - 1) rec_q.push_back(8'($urandom));
        end
        default: begin
          b = 8'($urandom);
          rec_q.push_back(b);
          if (is_a && k == 5) n = b[7] + b[4] + b[3] + 2 * b[2];
          else if (is_a) n = b[7] + b[4] + b[3] + b[2];
          else if (k == 6) n = b[7] + b[6] + b[5] + b[4] + b[3] + b[2] + b[1];
          else n = b[7] ? 2 : 0;
          repeat (n) rec_q.push_back(8'($urandom));
          if (!is_a && k == 19 && b[6]) begin
            r = $urandom_range(0, 2);
            rec_q.push_back(8'(r));
            repeat (r * 6) rec_q.push_back(8'($urandom));
          end
        end
      endcase
    end
  endfunction

  // One block; the length is sometimes cut short or overstated.
  function automatic void build_block(input logic [7:0] cat, input bit start);
    int          nrec, sel;
    logic [15:0] len;
    rec_q.delete();
    nrec = $urandom_range(1, 3);
    repeat (nrec) build_record(cat);
    len = 16'(rec_q.size() + 3);
    sel = $urandom_range(0, 99);
    if (sel < 10 && rec_q.size() > 1) len = len - 16'($urandom_range(1, rec_q.size() - 1));
    else if (sel < 14) len = len + 16'($urandom_range(1, 4));
    else if (sel < 16) len = 16'hFF00 | 16'($urandom);
    push_byte(cat, start);
    push_byte(len[15:8], 1'b0);
    push_byte(len[7:0], 1'b0);
    foreach (rec_q[i]) push_byte(rec_q[i], 1'b0);
  endfunction

  function automatic void build_payload();
    int         nblk, sel;
    bit         start;
    logic [7:0] cat;
    start = 1'b1;
    nblk = $urandom_range(1, 3);
    repeat (nblk) begin
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        // Bad block followed by bytes that only get ignored.
        push_byte(8'($urandom), start);
        push_byte(8'h00, 1'b0);
        push_byte(8'($urandom_range(0, 2)), 1'b0);
        repeat ($urandom_range(1, 4)) push_byte(8'($urandom), 1'b0);
      end else if (sel < 10) begin
        push_byte(8'($urandom), start);
        push_byte(8'h00, 1'b0);
        push_byte(8'h03, 1'b0);
      end else if (sel < 14) begin
        repeat ($urandom_range(1, 6)) begin
          push_byte(8'($urandom), start);
          start = 1'b0;
        end
      end else begin
        if (sel < 55) cat = CatA;
        else if (sel < 92) cat = CatB;
        else cat = 8'($urandom);
        build_block(cat, start);
      end
      start = 1'b0;
    end
  endfunction

  task automatic send_all();
    in_t x;
    while (beat_q.size() > 0) begin
      x = beat_q.pop_front();
      if ($urandom_range(0, 99) < tx_idle) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
        while ($urandom_range(0, 99) < tx_idle) @(posedge clk_i);
      end
      in_ch.valid <= 1'b1;
      in_ch.payload <= x;
      @(posedge clk_i);
      while (!in_ch.ready) @(posedge clk_i);
    end
    in_ch.valid <= 1'b0;
  endtask

  // The first edge lets the checker record the last accepted beat.
  task automatic wait_drained();
    @(posedge clk_i);
    while (tags_waiting != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n_bytes, input bit with_hold);
    int sent;
    sent = 0;
    while (sent < n_bytes) begin
      build_payload();
      sent += beat_q.size();
      if (with_hold && sent > n_bytes / 2) begin
        hold_req = 1;
        with_hold = 0;
      end
      send_all();
    end
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.payload = '0;
    tx_idle = 18;
    rx_idle = 50;
    hold_req = 0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Bad block, then ignored bytes.
    push_byte(8'hFF, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'hAB, 1'b0);
    // Empty block, then an opaque block and one whose FSPEC runs off the end.
    push_byte(8'h00, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h06, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h07, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h04, 1'b0);
    push_byte(8'h81, 1'b0);
    // Records with no items, and a four-byte FSPEC with every extension set.
    push_byte(CatB, 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'h09, 1'b0);
    push_byte(8'h00, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'h00, 1'b0);
    send_all();

    run_phase(350, 1'b1);
    wait_drained();
    repeat (5) @(posedge clk_i);
    tx_idle = 50;
    rx_idle = 18;
    run_phase(350, 1'b0);
    tx_idle = 0;
    rx_idle = 0;
    run_phase(350, 1'b0);

    wait_drained();
    repeat (10) @(posedge clk_i);
    if (fail_count == 0 && tags_waiting == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/ars_pkg.sv
design/ars_stream_if.sv
design/ars_parser.sv
design/asterix_record_splitter.sv
sim/ars_tag_checker.sv
sim/testbench.sv
